// ===== rtl/rfc3339_timestamp_parser_assert.svh =====
`ifndef RFC3339_TIMESTAMP_PARSER_ASSERT_SVH
`define RFC3339_TIMESTAMP_PARSER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RTSP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define RTSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rtsp_pkg.sv =====
`timescale 1ns / 1ps
package rtsp_pkg;

    localparam int FRACTION_DIGITS_DEF = 9;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] timestamp_ns;
        logic [3:0]         error_code;
    } t_out_item;

    typedef enum logic [3:0] {
        ERR_NONE     = 4'd0,
        ERR_SHAPE    = 4'd1,
        ERR_DIGIT    = 4'd2,
        ERR_DATE     = 4'd3,
        ERR_FRAC     = 4'd4,
        ERR_TZ_FORM  = 4'd5,
        ERR_TZ_RANGE = 4'd6,
        ERR_NO_TZ    = 4'd7,
        ERR_TRAIL    = 4'd8,
        ERR_RANGE    = 4'd9
    } t_err;

    typedef struct packed {
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [29:0] frac;
        logic [3:0]  frac_count;
        logic [6:0]  tz_hour;
        logic [6:0]  tz_min;
        logic        tz_neg;
    } t_fields;

    // 1 + days from 0000-03-01 to 1970-01-01 + one 400-year era of bias
    localparam logic [63:0] DAY_OFS = 64'd865566;

    function automatic logic [4:0] month_days(input logic [6:0] m, input logic leap);
        logic [4:0] d;
        unique case (m)
            7'd2:                      d = leap ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    // days before the month in a March-based year
    function automatic logic [8:0] doy_base(input logic [6:0] m);
        logic [8:0] d;
        unique case (m)
            7'd3:    d = 9'd0;
            7'd4:    d = 9'd31;
            7'd5:    d = 9'd61;
            7'd6:    d = 9'd92;
            7'd7:    d = 9'd122;
            7'd8:    d = 9'd153;
            7'd9:    d = 9'd184;
            7'd10:   d = 9'd214;
            7'd11:   d = 9'd245;
            7'd12:   d = 9'd275;
            7'd1:    d = 9'd306;
            default: d = 9'd337;
        endcase
        return d;
    endfunction

    function automatic logic [26:0] frac_scale(input logic [3:0] n);
        logic [26:0] s;
        unique case (n)
            4'd1:    s = 27'd100000000;
            4'd2:    s = 27'd10000000;
            4'd3:    s = 27'd1000000;
            4'd4:    s = 27'd100000;
            4'd5:    s = 27'd10000;
            4'd6:    s = 27'd1000;
            4'd7:    s = 27'd100;
            4'd8:    s = 27'd10;
            4'd9:    s = 27'd1;
            default: s = 27'd0;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/rtsp_mac.sv =====
`timescale 1ns / 1ps
module rtsp_mac
    import rtsp_pkg::*;
(
    input  logic signed [35:0] i_a,
    input  logic [26:0]        i_b,
    output logic signed [63:0] o_p
);

    assign o_p = i_a * $signed({1'b0, i_b});

endmodule

// ===== rtl/rtsp_parse.sv =====
`timescale 1ns / 1ps
module rtsp_parse
    import rtsp_pkg::*;
#(
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_clear,
    input  logic [7:0] i_char,
    output t_fields o_fields,
    output t_err    o_code
);

    typedef enum logic [5:0] {
        PH_PREFIX   = 6'b000001,
        PH_DECIDE   = 6'b000010,
        PH_FRACTION = 6'b000100,
        PH_ZONE     = 6'b001000,
        PH_AFTER_Z  = 6'b010000,
        PH_SINK     = 6'b100000
    } t_phase;

    localparam int FL_SHAPE   = 0;
    localparam int FL_DIGIT   = 1;
    localparam int FL_FRAC    = 2;
    localparam int FL_FORM    = 3;
    localparam int FL_TZDIGIT = 4;
    localparam int FL_NOTZ    = 5;
    localparam int FL_TRAIL   = 6;
    localparam logic [3:0] FD = 4'(FRACTION_DIGITS);

    t_phase      r_phase, n_phase;
    logic [4:0]  r_pos, n_pos;
    t_fields     r_f, n_f;
    logic [6:0]  r_flags, n_flags;
    logic [3:0]  r_ydig [4];
    logic [3:0]  n_ydig [4];

    logic        is_dig, do_dec;
    logic [3:0]  dig;
    logic [6:0]  fl;
    logic        lo_zero, leap;
    logic [4:0]  s_lo, s_hi;

    function automatic logic [6:0] acc7(input logic [6:0] x, input logic [3:0] d);
        return {x[3:0], 3'b0} + {x[5:0], 1'b0} + {3'b0, d};
    endfunction

    assign is_dig = (i_char >= 8'h30) && (i_char <= 8'h39);
    assign dig    = is_dig ? i_char[3:0] : 4'd0;

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_f     = r_f;
        n_flags = r_flags;
        n_ydig  = r_ydig;
        do_dec  = 1'b0;
        if (i_clear) begin
            n_phase = PH_PREFIX;
            n_pos   = '0;
            n_f     = '0;
            n_flags = '0;
            n_ydig  = '{default: 4'd0};
        end else if (i_accept) begin
            unique case (r_phase)
                PH_PREFIX: begin
                    priority if (r_pos == 5'd4 || r_pos == 5'd7) begin
                        if (i_char != 8'h2D) n_flags[FL_SHAPE] = 1'b1;
                    end else if (r_pos == 5'd10) begin
                        if (i_char != 8'h54) n_flags[FL_SHAPE] = 1'b1;
                    end else if (r_pos == 5'd13 || r_pos == 5'd16) begin
                        if (i_char != 8'h3A) n_flags[FL_SHAPE] = 1'b1;
                    end else begin
                        if (!is_dig) n_flags[FL_DIGIT] = 1'b1;
                        priority if (r_pos < 5'd4) begin
                            n_f.year = {r_f.year[10:0], 3'b0} + {r_f.year[12:0], 1'b0}
                                       + {10'd0, dig};
                            n_ydig[r_pos[1:0]] = dig;
                        end else if (r_pos < 5'd7) n_f.month = acc7(r_f.month, dig);
                        else if (r_pos < 5'd10)    n_f.day = acc7(r_f.day, dig);
                        else if (r_pos < 5'd13)    n_f.hour = acc7(r_f.hour, dig);
                        else if (r_pos < 5'd16)    n_f.minute = acc7(r_f.minute, dig);
                        else                       n_f.second = acc7(r_f.second, dig);
                    end
                    n_pos = r_pos + 5'd1;
                    if (n_pos >= 5'd19) n_phase = PH_DECIDE;
                end
                PH_DECIDE: begin
                    if (i_char == 8'h2E) begin
                        n_f.frac       = '0;
                        n_f.frac_count = '0;
                        n_phase        = PH_FRACTION;
                    end else begin
                        do_dec = 1'b1;
                    end
                end
                PH_FRACTION: begin
                    if (is_dig) begin
                        if (r_f.frac_count < FD) begin
                            n_f.frac = {r_f.frac[26:0], 3'b0} + {r_f.frac[28:0], 1'b0}
                                       + {26'd0, dig};
                            n_f.frac_count = r_f.frac_count + 4'd1;
                        end else begin
                            n_f.frac_count = FD + 4'd1;
                        end
                    end else begin
                        if (r_f.frac_count == 4'd0 || r_f.frac_count > FD)
                            n_flags[FL_FRAC] = 1'b1;
                        do_dec = 1'b1;
                    end
                end
                PH_ZONE: begin
                    if (r_pos >= 5'd5) begin
                        n_flags[FL_FORM] = 1'b1;
                        n_phase          = PH_SINK;
                    end else begin
                        if (r_pos == 5'd2) begin
                            if (i_char != 8'h3A) n_flags[FL_FORM] = 1'b1;
                        end else begin
                            if (!is_dig) n_flags[FL_TZDIGIT] = 1'b1;
                            if (r_pos < 5'd2) n_f.tz_hour = acc7(r_f.tz_hour, dig);
                            else              n_f.tz_min = acc7(r_f.tz_min, dig);
                        end
                        n_pos = r_pos + 5'd1;
                    end
                end
                PH_AFTER_Z: begin
                    n_flags[FL_TRAIL] = 1'b1;
                    n_phase           = PH_SINK;
                end
                PH_SINK: begin
                    n_phase = PH_SINK;
                end
                default: begin
                    n_phase = PH_SINK;
                end
            endcase
            if (do_dec) begin
                if (i_char == 8'h5A) begin
                    n_phase = PH_AFTER_Z;
                end else if (i_char == 8'h2B || i_char == 8'h2D) begin
                    n_f.tz_neg  = (i_char == 8'h2D);
                    n_f.tz_hour = '0;
                    n_f.tz_min  = '0;
                    n_pos       = '0;
                    n_phase     = PH_ZONE;
                end else begin
                    n_flags[FL_NOTZ] = 1'b1;
                    n_phase          = PH_SINK;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PREFIX;
            r_pos   <= '0;
            r_f     <= '0;
            r_flags <= '0;
            r_ydig  <= '{default: 4'd0};
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_f     <= n_f;
            r_flags <= n_flags;
            r_ydig  <= n_ydig;
        end
    end

    // end-of-string checks on the settled state
    always_comb begin
        fl = r_flags;
        if (r_phase == PH_PREFIX || r_phase == PH_DECIDE) begin
            fl[FL_SHAPE] = 1'b1;
        end else if (r_phase == PH_FRACTION) begin
            if (r_f.frac_count == 4'd0 || r_f.frac_count > FD) fl[FL_FRAC] = 1'b1;
            fl[FL_NOTZ] = 1'b1;
        end else if (r_phase == PH_ZONE && r_pos != 5'd5) begin
            fl[FL_FORM] = 1'b1;
        end
    end

    assign lo_zero = (r_ydig[2] == 4'd0) && (r_ydig[3] == 4'd0);
    assign s_lo    = {r_ydig[2], 1'b0} + {1'b0, r_ydig[3]};
    assign s_hi    = {r_ydig[0], 1'b0} + {1'b0, r_ydig[1]};
    assign leap    = lo_zero ? (s_hi[1:0] == 2'd0) : (s_lo[1:0] == 2'd0);

    always_comb begin
        priority if (fl[FL_SHAPE]) o_code = ERR_SHAPE;
        else if (fl[FL_DIGIT]) o_code = ERR_DIGIT;
        else if (r_f.month < 7'd1 || r_f.month > 7'd12 || r_f.day < 7'd1
                 || r_f.day > {2'b0, month_days(r_f.month, leap)}
                 || r_f.hour > 7'd23 || r_f.minute > 7'd59 || r_f.second > 7'd59)
            o_code = ERR_DATE;
        else if (fl[FL_FRAC]) o_code = ERR_FRAC;
        else if (fl[FL_FORM]) o_code = ERR_TZ_FORM;
        else if (fl[FL_TZDIGIT]) o_code = ERR_DIGIT;
        else if (r_f.tz_hour > 7'd23 || r_f.tz_min > 7'd59) o_code = ERR_TZ_RANGE;
        else if (fl[FL_NOTZ]) o_code = ERR_NO_TZ;
        else if (fl[FL_TRAIL]) o_code = ERR_TRAIL;
        else o_code = ERR_NONE;
    end

    assign o_fields = r_f;

endmodule

// ===== rtl/rtsp_conv.sv =====
`timescale 1ns / 1ps
module rtsp_conv
    import rtsp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_hold,
    input  t_fields   i_fields,
    input  t_err      i_code,
    output logic      o_done,
    output t_out_item o_result
);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b000000000001,
        ST_CHECK  = 12'b000000000010,
        ST_DIV100 = 12'b000000000100,
        ST_DIV400 = 12'b000000001000,
        ST_DAYS   = 12'b000000010000,
        ST_SDAY   = 12'b000000100000,
        ST_SHR    = 12'b000001000000,
        ST_SMIN   = 12'b000010000000,
        ST_STZ    = 12'b000100000000,
        ST_FRAC   = 12'b001000000000,
        ST_NS     = 12'b010000000000,
        ST_DONE   = 12'b100000000000
    } t_state;

    localparam logic signed [63:0] MIN_SEC  = -64'sd9223372037;
    localparam logic signed [63:0] MAX_SEC  = 64'sd9223372036;
    localparam logic [29:0]        MIN_FRAC = 30'd145224192;
    localparam logic [29:0]        MAX_FRAC = 30'd854775807;
    localparam logic [26:0]        RECIP25  = 27'd2622;

    t_state             r_state, n_state;
    logic signed [63:0] r_acc;
    logic [6:0]         r_q100;
    logic [4:0]         r_q400;
    logic [29:0]        r_frac;
    t_out_item          r_res;

    logic signed [35:0] mac_a;
    logic [26:0]        mac_b;
    logic signed [63:0] mac_p;
    logic [14:0]        t_year;
    logic [10:0]        tz_min_total;
    logic               range_bad;

    rtsp_mac u_mac (
        .i_a (mac_a),
        .i_b (mac_b),
        .o_p (mac_p)
    );

    assign t_year = 15'(i_fields.year) + 15'd400
                    - {14'd0, (i_fields.month <= 7'd2)};
    assign tz_min_total = 11'(i_fields.tz_hour) * 11'd60 + 11'(i_fields.tz_min);
    assign range_bad = (r_acc < MIN_SEC) || (r_acc > MAX_SEC)
                       || (r_acc == MIN_SEC && r_frac < MIN_FRAC)
                       || (r_acc == MAX_SEC && r_frac > MAX_FRAC);

    always_comb begin
        mac_a = '0;
        mac_b = '0;
        unique case (r_state)
            ST_DIV100: begin
                mac_a = 36'(t_year[14:2]);
                mac_b = RECIP25;
            end
            ST_DIV400: begin
                mac_a = 36'(t_year[14:4]);
                mac_b = RECIP25;
            end
            ST_DAYS: begin
                mac_a = 36'(t_year);
                mac_b = 27'd365;
            end
            ST_SDAY: begin
                mac_a = r_acc[35:0];
                mac_b = 27'd86400;
            end
            ST_SHR: begin
                mac_a = 36'(i_fields.hour);
                mac_b = 27'd3600;
            end
            ST_SMIN: begin
                mac_a = 36'(i_fields.minute);
                mac_b = 27'd60;
            end
            ST_STZ: begin
                mac_a = 36'(tz_min_total);
                mac_b = 27'd60;
            end
            ST_FRAC: begin
                mac_a = 36'(i_fields.frac);
                mac_b = frac_scale(i_fields.frac_count);
            end
            ST_NS: begin
                mac_a = r_acc[35:0];
                mac_b = 27'd1953125;
            end
            default: begin
                mac_a = '0;
                mac_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_start) n_state = ST_CHECK;
            ST_CHECK:  n_state = (i_code == ERR_NONE) ? ST_DIV100 : ST_DONE;
            ST_DIV100: n_state = ST_DIV400;
            ST_DIV400: n_state = ST_DAYS;
            ST_DAYS:   n_state = ST_SDAY;
            ST_SDAY:   n_state = ST_SHR;
            ST_SHR:    n_state = ST_SMIN;
            ST_SMIN:   n_state = ST_STZ;
            ST_STZ:    n_state = ST_FRAC;
            ST_FRAC:   n_state = ST_NS;
            ST_NS:     n_state = ST_DONE;
            ST_DONE:   if (!i_hold) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_CHECK: begin
                r_res.timestamp_ns <= '0;
                r_res.error_code   <= i_code;
            end
            ST_DIV100: r_q100 <= mac_p[22:16];
            ST_DIV400: r_q400 <= mac_p[20:16];
            ST_DAYS: begin
                r_acc <= mac_p + 64'(t_year[14:2]) - 64'(r_q100) + 64'(r_q400)
                         + 64'(doy_base(i_fields.month)) + 64'(i_fields.day) - DAY_OFS;
            end
            ST_SDAY: r_acc <= mac_p;
            ST_SHR:  r_acc <= r_acc + mac_p;
            ST_SMIN: r_acc <= r_acc + mac_p + 64'(i_fields.second);
            ST_STZ:  r_acc <= i_fields.tz_neg ? r_acc + mac_p : r_acc - mac_p;
            ST_FRAC: r_frac <= mac_p[29:0];
            ST_NS: begin
                if (range_bad) begin
                    r_res.timestamp_ns <= '0;
                    r_res.error_code   <= ERR_RANGE;
                end else begin
                    r_res.timestamp_ns <= (mac_p <<< 9) + 64'(r_frac);
                    r_res.error_code   <= ERR_NONE;
                end
            end
            default: begin
                r_q100 <= r_q100;
            end
        endcase
    end

    assign o_done   = (r_state == ST_DONE) && !i_hold;
    assign o_result = r_res;

endmodule

// ===== rtl/rfc3339_timestamp_parser.sv =====
`timescale 1ns / 1ps
// channel | valid      | stall       | payload
// in      | i_in_valid | o_in_stall  | i_in  (t_in_item: char_byte, last_byte)
// out     | o_out_valid| i_out_stall | o_out (t_out_item: timestamp_ns, error_code)
// Characters are taken one per cycle. After the last character the input stalls
// while one shared multiply-accumulate unit builds the result.
// A string rejected at the end-of-string check skips the arithmetic.
// Reset (synchronous, active low) clears the parse state and the sequencer.
// A stalled output holds the result; a following string's result then waits and keeps the input stalled.
module rfc3339_timestamp_parser
    import rtsp_pkg::*;
#(
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    `include "rfc3339_timestamp_parser_assert.svh"

    logic      r_busy;
    logic      r_out_valid;
    t_out_item r_out;

    logic      in_acc, start, done, hold;
    t_fields   fields;
    t_err      code;
    t_out_item result;

    assign in_acc = i_in_valid && !r_busy;
    assign start  = in_acc && i_in.last_byte;
    assign hold   = r_out_valid && i_out_stall;

    rtsp_parse #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_acc),
        .i_clear  (done),
        .i_char   (i_in.char_byte),
        .o_fields (fields),
        .o_code   (code)
    );

    rtsp_conv u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_hold   (hold),
        .i_fields (fields),
        .i_code   (code),
        .o_done   (done),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (start) r_busy <= 1'b1;
            else if (done) r_busy <= 1'b0;
            if (done) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) r_out <= result;
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `RTSP_ASSERT_NEXT(a_last_stalls, i_clk, i_rst_n, start, r_busy, "last item did not stall input")
    `RTSP_ASSERT_NOW(a_done_busy, i_clk, i_rst_n, done, r_busy, "result without a string")
    `RTSP_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, r_out_valid && r_out.error_code != ERR_NONE, r_out.timestamp_ns == 64'sd0, "error result carries nonzero time")
    `RTSP_ASSERT_NOW(a_done_room, i_clk, i_rst_n, done, !hold, "result overwrote a held item")

endmodule
